/* rtl/csoc_pkg.sv */
// ----------------------------------------------------------------------------
// csoc_pkg
// Shared types and constants for the cone/sphere occlusion counter.
// ----------------------------------------------------------------------------
package csoc_pkg;

  localparam int FRAC_BITS = 14;
  localparam int RAY_LOG2  = 13;
  localparam int RAY_COUNT = 1 << RAY_LOG2;
  localparam int PTR_W     = RAY_LOG2;
  localparam int CNT_W     = RAY_LOG2 + 1;

  localparam int COMP_W    = 16;
  localparam int SIN_W     = 15;
  localparam int OPND_W    = 17;
  localparam int SQ_W      = 2 * OPND_W;
  localparam int ROOT_W    = FRAC_BITS + 1;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int ITER_W    = 4;

  localparam int PROD_W    = 2 * COMP_W;
  localparam int DOT_W     = PROD_W + 1;

  localparam int HIT_W     = 14;
  localparam int BYTE_W    = 8;
  localparam int BSUM_W    = CNT_W + 10;
  localparam int BYTE_SCALE = 510;

  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FRAC_BITS);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [COMP_W-1:0] ray_x;
    logic signed [COMP_W-1:0] ray_z;
    logic        [SIN_W-1:0]  occluder_sin;
    logic signed [COMP_W-1:0] axis_cos;
  } in_t;

  typedef struct packed {
    logic [HIT_W-1:0]  hit_count;
    logic [BYTE_W-1:0] occlusion_byte;
  } out_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] z;
  } ray_t;

  typedef struct packed {
    logic                     start;
    logic signed [OPND_W-1:0] operand;
  } sqrt_req_t;

  typedef struct packed {
    logic clear;
    logic data_valid;
  } scan_ctl_t;

endpackage

/* rtl/cone_sphere_occlusion_count.sv */
// ----------------------------------------------------------------------------
// cone_sphere_occlusion_count
// Ray store with occlusion query: counts rays inside an occluder's cone.
// ----------------------------------------------------------------------------
// A load beat writes one ray at a wrapping pointer. A query beat has its
// result registered after two passes through the shared bit-serial square
// root unit, one root bit per cycle, then a scan of the whole ray store
// through its single read port, one ray per cycle, then a short drain and
// rounding. One item is worked on at a time; a finished result waits in the
// output register while the next item is taken, and a query that finishes
// while an earlier result still waits holds until that result is taken. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
module cone_sphere_occlusion_count (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  csoc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output csoc_pkg::out_t  out_data
);
  import csoc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ROOT_C = 3'd1;
  localparam logic [2:0] ST_ROOT_S = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_BYTE   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic [PTR_W-1:0]         load_ptr_r;
  logic [PTR_W-1:0]         rd_addr_r;
  logic                     rd_issue_r;
  logic                     out_valid_r;
  out_t                     out_data_r;
  logic signed [COMP_W-1:0] cos_r;
  logic [SIN_W-1:0]         sin_r;
  logic [ROOT_W-1:0]        dir_x_r;
  logic [ROOT_W-1:0]        thr_root_r;
  logic [BSUM_W-1:0]        bsum_r;

  logic       in_beat, load_beat, query_beat;
  logic       rd_en;
  logic       out_load;
  sqrt_req_t  sq_req;
  logic       sq_done;
  logic [ROOT_W-1:0] sq_root;
  scan_ctl_t  scan_ctl;
  logic       scan_busy;
  logic [CNT_W-1:0] hits;
  logic [CNT_W-1:0] miss;
  ray_t       wr_ray, rd_ray;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_beat    = in_valid && in_ready;
  assign load_beat  = in_beat && (in_data.kind == KIND_LOAD);
  assign query_beat = in_beat && (in_data.kind == KIND_QUERY);
  assign rd_en      = (state_r == ST_SCAN);
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign miss       = CNT_W'(RAY_COUNT) - hits;

  assign wr_ray.x = in_data.ray_x;
  assign wr_ray.z = in_data.ray_z;

  always_comb begin
    sq_req.start   = 1'b0;
    sq_req.operand = OPND_W'(in_data.axis_cos);
    if (query_beat) begin
      sq_req.start = 1'b1;
    end else if (state_r == ST_ROOT_C && sq_done) begin
      sq_req.start   = 1'b1;
      sq_req.operand = $signed({{(OPND_W-SIN_W){1'b0}}, sin_r});
    end
  end

  assign scan_ctl.clear      = query_beat;
  assign scan_ctl.data_valid = rd_issue_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (query_beat) begin
          state_nxt = ST_ROOT_C;
        end
      end
      ST_ROOT_C: begin
        if (sq_done) begin
          state_nxt = ST_ROOT_S;
        end
      end
      ST_ROOT_S: begin
        if (sq_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_addr_r == PTR_W'(RAY_COUNT - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_issue_r && !scan_busy) begin
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_ptr_r  <= '0;
      rd_addr_r   <= '0;
      rd_issue_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_issue_r <= rd_en;
      if (load_beat) begin
        load_ptr_r <= load_ptr_r + 1'b1;
      end
      if (query_beat) begin
        rd_addr_r <= '0;
      end else if (rd_en) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_beat) begin
      cos_r <= in_data.axis_cos;
      sin_r <= in_data.occluder_sin;
    end
    if (state_r == ST_ROOT_C && sq_done) begin
      dir_x_r <= sq_root;
    end
    if (state_r == ST_ROOT_S && sq_done) begin
      thr_root_r <= sq_root;
    end
    if (state_r == ST_BYTE) begin
      bsum_r <= BSUM_W'(miss) * BSUM_W'(BYTE_SCALE) + BSUM_W'(RAY_COUNT);
    end
    if (out_load) begin
      out_data_r.hit_count      <= HIT_W'(hits);
      out_data_r.occlusion_byte <= bsum_r[RAY_LOG2+1 +: BYTE_W];
    end
  end

  csoc_ray_ram u_ray_ram (
    .clk     (clk),
    .wr_en   (load_beat),
    .wr_addr (load_ptr_r),
    .wr_data (wr_ray),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_ray)
  );

  csoc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .done  (sq_done),
    .root  (sq_root)
  );

  csoc_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .ray      (rd_ray),
    .dir_x    (dir_x_r),
    .dir_z    (cos_r),
    .thr_root (thr_root_r),
    .busy     (scan_busy),
    .hits     (hits)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/csoc_ray_ram.sv */
// ----------------------------------------------------------------------------
// csoc_ray_ram
// Ray store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csoc_ray_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [csoc_pkg::PTR_W-1:0] wr_addr,
  input  csoc_pkg::ray_t             wr_data,
  input  logic                       rd_en,
  input  logic [csoc_pkg::PTR_W-1:0] rd_addr,
  output csoc_pkg::ray_t             rd_data
);
  import csoc_pkg::*;

  ray_t mem [RAY_COUNT];
  ray_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/csoc_isqrt.sv */
// ----------------------------------------------------------------------------
// csoc_isqrt
// Bit-serial floor(sqrt(1 - v^2)) in fixed point, one root bit per cycle.
// ----------------------------------------------------------------------------
module csoc_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  csoc_pkg::sqrt_req_t         req,
  output logic                        done,
  output logic [csoc_pkg::ROOT_W-1:0] root
);
  import csoc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_RAD  = 2'd2;
  localparam logic [1:0] ST_ITER = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [ITER_W-1:0]        iter_r;
  logic                     done_r, done_nxt;
  logic signed [OPND_W-1:0] opnd_r;
  logic [SQ_W-1:0]          sq_r;
  logic [RAD_W-1:0]         rad_r;
  logic [REM_W-1:0]         rem_r;
  logic [ROOT_W-1:0]        root_r;

  logic [REM_W-1:0]         rem_t;
  logic [REM_W-1:0]         trial;
  logic                     take;
  logic signed [SQ_W-1:0]   sq_full;

  assign rem_t   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial   = REM_W'({root_r, 2'b01});
  assign take    = rem_t >= trial;
  assign sq_full = opnd_r * opnd_r;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ:   state_nxt = ST_RAD;
      ST_RAD:  state_nxt = ST_ITER;
      ST_ITER: begin
        if (iter_r == ITER_W'(ROOT_W - 1)) begin
          state_nxt = ST_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          opnd_r <= req.operand;
        end
      end
      ST_SQ: begin
        sq_r <= sq_full;
      end
      ST_RAD: begin
        rad_r  <= (sq_r >= ONE_SQ) ? '0 : RAD_W'(ONE_SQ - sq_r);
        rem_r  <= '0;
        root_r <= '0;
        iter_r <= '0;
      end
      ST_ITER: begin
        rad_r  <= rad_r << 2;
        iter_r <= iter_r + 1'b1;
        if (take) begin
          rem_r  <= rem_t - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_t;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      default: begin
        opnd_r <= opnd_r;
      end
    endcase
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* rtl/csoc_scan.sv */
// ----------------------------------------------------------------------------
// csoc_scan
// Dot product, threshold compare and hit counter over streamed rays.
// ----------------------------------------------------------------------------
module csoc_scan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  csoc_pkg::scan_ctl_t                ctl,
  input  csoc_pkg::ray_t                     ray,
  input  logic [csoc_pkg::ROOT_W-1:0]        dir_x,
  input  logic signed [csoc_pkg::COMP_W-1:0] dir_z,
  input  logic [csoc_pkg::ROOT_W-1:0]        thr_root,
  output logic                               busy,
  output logic [csoc_pkg::CNT_W-1:0]         hits
);
  import csoc_pkg::*;

  logic                     v1_r, v2_r;
  logic signed [PROD_W-1:0] px_r, pz_r;
  logic                     hit_r;
  logic [CNT_W-1:0]         hits_r;

  logic signed [COMP_W-1:0] dir_x_s;
  logic signed [DOT_W-1:0]  dot;
  logic signed [DOT_W-1:0]  thr;

  assign dir_x_s = $signed({1'b0, dir_x});
  assign dot     = DOT_W'(px_r) + DOT_W'(pz_r);
  assign thr     = $signed(DOT_W'({thr_root, {FRAC_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      hits_r <= '0;
    end else begin
      v1_r <= ctl.data_valid;
      v2_r <= v1_r;
      if (ctl.clear) begin
        hits_r <= '0;
      end else if (v2_r && hit_r) begin
        hits_r <= hits_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    px_r  <= dir_x_s * ray.x;
    pz_r  <= dir_z * ray.z;
    hit_r <= dot > thr;
  end

  assign busy = v1_r | v2_r;
  assign hits = hits_r;

endmodule
